>>> rtl/sabc_pkg.sv
package sabc_pkg;

    typedef enum logic [1:0] {
        CMD_WRITE   = 2'd0,
        CMD_READ    = 2'd1,
        CMD_RESTART = 2'd2,
        CMD_BLEND   = 2'd3
    } cmd_e;

    typedef enum logic [2:0] {
        REG_POS_X         = 3'd0,
        REG_POS_Y         = 3'd1,
        REG_SPRITE_WIDTH  = 3'd2,
        REG_SPRITE_HEIGHT = 3'd3,
        REG_SCREEN_WIDTH  = 3'd4,
        REG_SCREEN_HEIGHT = 3'd5
    } reg_idx_e;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int RGB_W      = 24;

    typedef struct packed {
        cmd_e        command;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [31:0] pixel;
    } in_item_t;

    typedef struct packed {
        logic [RGB_W-1:0] read_data;
        logic             drawn;
        logic [7:0]       draw_x;
        logic [7:0]       draw_y;
        logic             sprite_done;
    } out_item_t;

endpackage

>>> rtl/sabc_stream_if.sv
interface sabc_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/sabc_blend.sv
module sabc_blend (
    input  logic [31:0]              pixel,
    input  logic [sabc_pkg::RGB_W-1:0] dst,
    output logic [sabc_pkg::RGB_W-1:0] mixed
);
    import sabc_pkg::*;

    logic [7:0] alpha;

    assign alpha = pixel[31:24];

    for (genvar ch = 0; ch < 3; ch++) begin : g_chan
        logic [7:0]         s;
        logic [7:0]         d;
        logic signed [8:0]  diff;
        logic signed [17:0] prod;
        logic signed [17:0] num_s;
        logic [15:0]        num;
        logic [16:0]        quot;

        assign s     = pixel[ch*8 +: 8];
        assign d     = dst[ch*8 +: 8];
        assign diff  = $signed({1'b0, s}) - $signed({1'b0, d});
        assign prod  = $signed({1'b0, alpha}) * diff;
        // a*s + (255-a)*d + 127 == 255*d + a*(s-d) + 127, never negative
        assign num_s = $signed({2'b00, d, 8'h00}) - $signed({10'd0, d}) + prod + 18'sd127;
        assign num   = num_s[15:0];
        // exact divide by 255 for any 16-bit numerator up to 65534
        assign quot  = ({1'b0, num} + 17'(num[15:8]) + 17'd1) >> 8;
        assign mixed[ch*8 +: 8] = quot[7:0];
    end
endmodule

>>> rtl/sprite_alpha_blit_with_clip.sv
// an accepted item passes the stage-1 registers and then the output register
// throughput: one item per cycle unless the response stalls; the frame store is
// read at acceptance and written as the item leaves stage 1; same-pixel writes bypass
// reset: walk counters cleared, config registers set to their defaults,
// pipeline emptied; the frame store holds no reset and no clearing pass is run
module sprite_alpha_blit_with_clip #(
    parameter int MAX_SCREEN_WIDTH  = 256,
    parameter int MAX_SCREEN_HEIGHT = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [sabc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sabc_pkg::CFG_DATA_W-1:0] cfg_data,
    sabc_stream_if.sink                   request,
    sabc_stream_if.source                 response
);
    import sabc_pkg::*;

    localparam int DEPTH = MAX_SCREEN_WIDTH * MAX_SCREEN_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(MAX_SCREEN_WIDTH);
    localparam int YW    = $clog2(MAX_SCREEN_HEIGHT);

    logic [RGB_W-1:0] mem [DEPTH];

    logic signed [9:0] pos_x_reg;
    logic signed [9:0] pos_y_reg;
    logic [8:0]        sprite_width_reg;
    logic [8:0]        sprite_height_reg;
    logic [8:0]        screen_width_reg;
    logic [8:0]        screen_height_reg;

    logic [7:0] walk_col_reg, walk_col_next;
    logic [7:0] walk_row_reg, walk_row_next;

    logic             s1_valid_reg;
    cmd_e             s1_cmd_reg;
    logic             s1_inside_reg;
    logic [AW-1:0]    s1_addr_reg;
    logic [31:0]      s1_pixel_reg;
    logic [7:0]       s1_dx_reg;
    logic [7:0]       s1_dy_reg;
    logic             s1_done_reg;
    logic             fwd_hit_reg;
    logic [RGB_W-1:0] fwd_data_reg;
    logic [RGB_W-1:0] rdata_reg;

    logic      out_valid_reg;
    out_item_t out_item_reg, out_item_next;

    in_item_t          item;
    logic              accept;
    logic              out_free;
    logic              s1_move;
    logic signed [11:0] col_pos;
    logic signed [11:0] row_pos;
    logic              blend_inside;
    logic              rw_inside;
    logic              acc_inside;
    logic [XW-1:0]     sel_x;
    logic [YW-1:0]     sel_y;
    logic [AW-1:0]     acc_addr;
    logic              row_end;
    logic              last_row;
    logic              acc_done;
    logic [RGB_W-1:0]  dst;
    logic [RGB_W-1:0]  mixed;
    logic              wr_en;
    logic [RGB_W-1:0]  wr_data;

    assign item     = request.data;
    assign out_free = !out_valid_reg || response.ready;
    assign s1_move  = s1_valid_reg && out_free;
    assign request.ready = !s1_valid_reg || out_free;
    assign accept   = request.valid && request.ready;

    assign response.valid = out_valid_reg;
    assign response.data  = out_item_reg;

    // sprite pixel placement and clipping
    assign col_pos = 12'(pos_x_reg) + $signed({4'b0000, walk_col_reg});
    assign row_pos = 12'(pos_y_reg) + $signed({3'b000, sprite_height_reg}) - 12'sd1
                     - $signed({4'b0000, walk_row_reg});
    assign blend_inside = (col_pos >= 12'sd0) && (col_pos < $signed({3'b000, screen_width_reg}))
                          && (int'(col_pos) < MAX_SCREEN_WIDTH)
                          && (row_pos >= 12'sd0)
                          && (row_pos < $signed({3'b000, screen_height_reg}))
                          && (int'(row_pos) < MAX_SCREEN_HEIGHT);
    assign rw_inside = (int'(item.x) < MAX_SCREEN_WIDTH) && (int'(item.y) < MAX_SCREEN_HEIGHT);

    always_comb
    begin
        sel_x      = XW'(item.x);
        sel_y      = YW'(item.y);
        acc_inside = rw_inside;
        if (item.command == CMD_BLEND)
        begin
            sel_x      = XW'(col_pos);
            sel_y      = YW'(row_pos);
            acc_inside = blend_inside;
        end
        else if (item.command == CMD_RESTART)
        begin
            acc_inside = 1'b0;
        end
    end

    assign acc_addr = AW'(AW'(sel_y) * AW'(MAX_SCREEN_WIDTH) + AW'(sel_x));

    // sprite walk
    assign row_end  = ({1'b0, walk_col_reg} + 9'd1 >= sprite_width_reg) || (walk_col_reg == 8'hFF);
    assign last_row = ({1'b0, walk_row_reg} + 9'd1 >= sprite_height_reg)
                      || (walk_row_reg == 8'hFF);
    assign acc_done = row_end && last_row;

    always_comb
    begin
        walk_col_next = walk_col_reg;
        walk_row_next = walk_row_reg;
        if (accept)
        begin
            unique case (item.command)
                CMD_RESTART:
                begin
                    walk_col_next = '0;
                    walk_row_next = '0;
                end
                CMD_BLEND:
                begin
                    if (row_end)
                    begin
                        walk_col_next = '0;
                        walk_row_next = last_row ? 8'd0 : walk_row_reg + 8'd1;
                    end
                    else
                    begin
                        walk_col_next = walk_col_reg + 8'd1;
                    end
                end
                default:
                begin
                    walk_col_next = walk_col_reg;
                end
            endcase
        end
    end

    // read-modify-write stage
    assign dst = fwd_hit_reg ? fwd_data_reg : rdata_reg;

    sabc_blend u_blend (
        .pixel (s1_pixel_reg),
        .dst   (dst),
        .mixed (mixed)
    );

    assign wr_en   = s1_move && s1_inside_reg
                     && ((s1_cmd_reg == CMD_WRITE) || (s1_cmd_reg == CMD_BLEND));
    assign wr_data = (s1_cmd_reg == CMD_WRITE) ? s1_pixel_reg[RGB_W-1:0] : mixed;

    always_comb
    begin
        out_item_next             = '0;
        out_item_next.sprite_done = (s1_cmd_reg == CMD_BLEND) && s1_done_reg;
        if (s1_inside_reg)
        begin
            unique case (s1_cmd_reg)
                CMD_READ:
                begin
                    out_item_next.read_data = dst;
                end
                CMD_BLEND:
                begin
                    out_item_next.read_data = mixed;
                    out_item_next.drawn     = 1'b1;
                    out_item_next.draw_x    = s1_dx_reg;
                    out_item_next.draw_y    = s1_dy_reg;
                end
                default:
                begin
                    out_item_next.read_data = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[s1_addr_reg] <= wr_data;
        end
        if (accept)
        begin
            rdata_reg <= mem[acc_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg    <= item.command;
            s1_inside_reg <= acc_inside;
            s1_addr_reg   <= acc_addr;
            s1_pixel_reg  <= item.pixel;
            s1_dx_reg     <= col_pos[7:0];
            s1_dy_reg     <= row_pos[7:0];
            s1_done_reg   <= acc_done;
            fwd_hit_reg   <= wr_en && (s1_addr_reg == acc_addr);
            fwd_data_reg  <= wr_data;
        end
        if (s1_move)
        begin
            out_item_reg <= out_item_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            walk_col_reg      <= '0;
            walk_row_reg      <= '0;
            pos_x_reg         <= '0;
            pos_y_reg         <= '0;
            sprite_width_reg  <= 9'd1;
            sprite_height_reg <= 9'd1;
            screen_width_reg  <= 9'd256;
            screen_height_reg <= 9'd256;
        end
        else
        begin
            walk_col_reg <= walk_col_next;
            walk_row_reg <= walk_row_next;
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (response.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_POS_X:         pos_x_reg         <= $signed(cfg_data);
                    REG_POS_Y:         pos_y_reg         <= $signed(cfg_data);
                    REG_SPRITE_WIDTH:  sprite_width_reg  <= cfg_data[8:0];
                    REG_SPRITE_HEIGHT: sprite_height_reg <= cfg_data[8:0];
                    REG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data[8:0];
                    REG_SCREEN_HEIGHT: screen_height_reg <= cfg_data[8:0];
                    default:           pos_x_reg         <= pos_x_reg;
                endcase
            end
        end
    end
endmodule
